/* hw/rtl/csnb_pkg.sv */
package csnb_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    // Scaled sensitivity magnitude limit: quotients must stay below 2^Q_W
    localparam int Q_W = 62;

    // Multiply-accumulate request from the sequencer
    typedef struct packed {
        logic start;
        logic clear;
        logic sub;
    } mac_cmd_t;

    // Division request from the sequencer
    typedef struct packed {
        logic start;
    } div_cmd_t;

endpackage

/* hw/rtl/csnb_mac.sv */
module csnb_mac #(
    parameter int DATA_WIDTH = csnb_pkg::DATA_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  csnb_pkg::mac_cmd_t                    cmd,
    input  logic signed [63:0]                    op_a,
    input  logic signed [DATA_WIDTH:0]            op_b,
    output logic                                  busy,
    output logic signed [DATA_WIDTH+62:0]         acc
);

    localparam int ACC_W = DATA_WIDTH + 63;

    logic signed [ACC_W-1:0]  a_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [DATA_WIDTH:0]      bmag_reg;
    logic                     neg_reg;
    logic                     busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (cmd.start) begin
            a_reg    <= ACC_W'(op_a);
            bmag_reg <= op_b[DATA_WIDTH] ? (DATA_WIDTH+1)'(-op_b) : (DATA_WIDTH+1)'(op_b);
            neg_reg  <= op_b[DATA_WIDTH] ^ cmd.sub;
            if (cmd.clear) begin
                acc_reg <= '0;
            end
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            // one multiplier bit per cycle, LSB first
            if (bmag_reg[0]) begin
                acc_reg <= neg_reg ? acc_reg - a_reg : acc_reg + a_reg;
            end
            a_reg    <= a_reg <<< 1;
            bmag_reg <= bmag_reg >> 1;
            if (bmag_reg[DATA_WIDTH:1] == '0) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;

endmodule

/* hw/rtl/csnb_div.sv */
module csnb_div #(
    parameter int DATA_WIDTH = csnb_pkg::DATA_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  csnb_pkg::div_cmd_t               cmd,
    input  logic [2*DATA_WIDTH:0]            nmag,
    input  logic [2*DATA_WIDTH:0]            dval,
    output logic                             busy,
    output logic [csnb_pkg::Q_W-1:0]         quot,
    output logic                             ovf
);

    localparam int NM_W  = 2 * DATA_WIDTH + 1;
    localparam int F     = DATA_WIDTH - 2;
    localparam int NW    = NM_W + F;
    localparam int CNT_W = $clog2(NW + 1);
    localparam int Q_W   = csnb_pkg::Q_W;

    logic [NW-1:0]    dvd_reg;
    logic [NM_W-1:0]  d_reg;
    logic [NM_W-1:0]  rem_reg;
    logic [Q_W-1:0]   q_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [NM_W:0]    rem2;
    logic [NM_W:0]    rem_sub;
    logic             ge;
    logic [NM_W-1:0]  rem_new;

    always_comb begin
        rem2    = {rem_reg, dvd_reg[NW-1]};
        rem_sub = rem2 - {1'b0, d_reg};
        ge      = rem2 >= {1'b0, d_reg};
        rem_new = ge ? rem_sub[NM_W-1:0] : rem2[NM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (cmd.start) begin
            dvd_reg  <= {nmag, F'(0)};
            d_reg    <= dval;
            rem_reg  <= '0;
            q_reg    <= '0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= CNT_W'(NW);
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_new;
            q_reg   <= {q_reg[Q_W-2:0], ge};
            // a one leaving the top means the quotient reached the limit
            ovf_reg <= ovf_reg | q_reg[Q_W-1];
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;
    assign ovf  = ovf_reg;

endmodule

/* hw/rtl/complex_secant_null_balance_top.sv */
// Complex secant null balance. Each input transfer reports the complex stimulus that was
// applied and the detector reading for it; the block answers with one result transfer
// that carries the next stimulus and a status (apply next, balanced, overrange, step limit,
// aborted, singular). All products go through one bit-serial multiply-accumulate unit, which
// finishes early when the multiplier has leading zeros, and the two sensitivity quotients
// go through a restoring divider that yields one bit per cycle. s_tready is high only while
// no item is in work; a result waits in the output register until taken.
module complex_secant_null_balance_top #(
    parameter int DATA_WIDTH = csnb_pkg::DATA_WIDTH_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    // stim_real, stim_imag, resp_real, resp_imag, probe_real, probe_imag, abort
    input  logic [((6*DATA_WIDTH+1+7)/8)*8-1:0]         s_tdata,
    // req_type
    input  logic                                        s_tuser,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // next_real, next_imag, status, step_index
    output logic [((2*DATA_WIDTH+11+7)/8)*8-1:0]        m_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    input  logic                                        cfg_we,
    input  logic [1:0]                                  cfg_index,
    input  logic [61:0]                                 cfg_wdata
);

    localparam int W      = DATA_WIDTH;
    localparam int F      = W - 2;
    localparam int ACC_W  = W + 63;
    localparam int NM_W   = 2 * W + 1;
    localparam int OUT_W  = ((2*W+11+7)/8)*8;
    localparam int Q_W    = csnb_pkg::Q_W;

    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_MAX_AMP   = 2'd1;
    localparam logic [1:0] CFG_MAX_STEPS = 2'd2;

    localparam logic [2:0] ST_APPLY      = 3'd0;
    localparam logic [2:0] ST_BALANCED   = 3'd1;
    localparam logic [2:0] ST_OVERRANGE  = 3'd2;
    localparam logic [2:0] ST_STEP_LIMIT = 3'd3;
    localparam logic [2:0] ST_ABORTED    = 3'd4;
    localparam logic [2:0] ST_SINGULAR   = 3'd5;

    localparam logic signed [W+3:0] SAT_HI = {5'b00000, {(W-1){1'b1}}};
    localparam logic signed [W+3:0] SAT_LO = {5'b11111, {(W-1){1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_SQ2, S_SQ3, S_B2, S_B3,
        S_N1, S_N2, S_N3, S_N4, S_D1, S_D2,
        S_Q0, S_Q1, S_Q2, S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_OUT
    } state_t;

    state_t state_reg;

    logic [61:0] thr_reg;
    logic [61:0] amp_reg;
    logic [7:0]  maxs_reg;

    logic signed [W-1:0] sr_reg, si_reg, rr_reg, ri_reg, pr_reg, pi_reg;
    logic signed [W-1:0] prev_sr_reg, prev_si_reg, prev_rr_reg, prev_ri_reg;
    logic signed [W:0]   dsr_reg, dsi_reg, drr_reg, dri_reg;
    logic                abort_reg, first_reg;
    logic [7:0]          cnt_reg;
    logic                run_reg;
    logic                nre_neg_reg, nim_neg_reg;
    logic [NM_W-1:0]     nre_mag_reg, nim_mag_reg, d_reg;
    logic signed [63:0]  kr_reg, ki_reg;
    logic signed [W+2:0] cr_reg, ci_reg;
    logic signed [W-1:0] nxt_r_reg, nxt_i_reg;
    logic                satd_reg;

    logic signed [W-1:0] res_r_reg, res_i_reg;
    logic [2:0]          res_st_reg;
    logic [7:0]          res_idx_reg;

    logic signed [W-1:0] m_r_reg, m_i_reg;
    logic [2:0]          m_st_reg;
    logic [7:0]          m_idx_reg;
    logic                m_tvalid_reg;

    csnb_pkg::mac_cmd_t    mac_cmd;
    logic signed [63:0]    mac_a;
    logic signed [W:0]     mac_b;
    logic                  mac_busy;
    logic signed [ACC_W-1:0] acc;

    csnb_pkg::div_cmd_t    div_cmd;
    logic [NM_W-1:0]       div_n;
    logic                  div_busy;
    logic [Q_W-1:0]        div_q;
    logic                  div_ovf;

    logic                  accept;
    logic [8:0]            k_w;
    logic                  k_limit;
    logic [ACC_W-1:0]      acc_mag;
    logic [ACC_W-1:0]      acc_shr;
    logic [ACC_W-1:0]      shr_lim;
    logic [W+1:0]          shr_v;
    logic signed [W+2:0]   c_val;
    logic signed [W+3:0]   sum_r, sum_i;
    logic signed [W-1:0]   nr_sat, ni_sat;
    logic                  sat_any;
    logic signed [ACC_W-1:0] thr_ext, amp_ext;
    logic                  over_amp;
    logic signed [63:0]    q_signed;

    function automatic logic sat_ovf(input logic signed [W+3:0] v);
        sat_ovf = (v > SAT_HI) || (v < SAT_LO);
    endfunction

    function automatic logic signed [W-1:0] sat_val(input logic signed [W+3:0] v);
        if (v > SAT_HI) begin
            sat_val = SAT_HI[W-1:0];
        end else if (v < SAT_LO) begin
            sat_val = SAT_LO[W-1:0];
        end else begin
            sat_val = v[W-1:0];
        end
    endfunction

    csnb_mac #(.DATA_WIDTH(DATA_WIDTH)) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mac_cmd),
        .op_a    (mac_a),
        .op_b    (mac_b),
        .busy    (mac_busy),
        .acc     (acc)
    );

    csnb_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (div_cmd),
        .nmag    (div_n),
        .dval    (d_reg),
        .busy    (div_busy),
        .quot    (div_q),
        .ovf     (div_ovf)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && (state_reg == S_IDLE);

    always_comb begin
        k_w      = {1'b0, cnt_reg} + 9'd1;
        k_limit  = k_w >= {1'b0, maxs_reg};
        acc_mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        // correction: drop F fraction bits, clamp magnitude, restore sign
        acc_shr  = acc_mag >> F;
        shr_lim  = ACC_W'(1) << (W + 1);
        shr_v    = (acc_shr > shr_lim) ? (W+2)'(shr_lim) : (W+2)'(acc_shr);
        c_val    = acc[ACC_W-1] ? -$signed({1'b0, shr_v}) : $signed({1'b0, shr_v});
        if (state_reg == S_DEC) begin
            sum_r = (W+4)'(sr_reg) + (W+4)'(pr_reg);
            sum_i = (W+4)'(si_reg) + (W+4)'(pi_reg);
        end else begin
            sum_r = (W+4)'(sr_reg) - (W+4)'(cr_reg);
            sum_i = (W+4)'(si_reg) - (W+4)'(ci_reg);
        end
        nr_sat   = sat_val(sum_r);
        ni_sat   = sat_val(sum_i);
        sat_any  = sat_ovf(sum_r) || sat_ovf(sum_i);
        thr_ext  = ACC_W'(thr_reg);
        amp_ext  = ACC_W'(amp_reg);
        over_amp = satd_reg || (acc > amp_ext);
        q_signed = 64'(div_q);
    end

    // operand selection for the shared multiply-accumulate unit and start requests for the divider
    always_comb begin
        mac_cmd = '0;
        mac_a   = '0;
        mac_b   = '0;
        div_cmd = '0;
        div_n   = nre_mag_reg;
        if (!mac_busy) begin
            unique case (state_reg)
                S_DEC: begin
                    if (first_reg) begin
                        mac_cmd = '{start: 1'b1, clear: 1'b1, sub: 1'b0};
                        mac_a   = 64'(nr_sat);
                        mac_b   = (W+1)'(nr_sat);
                    end else if (!k_limit) begin
                        mac_cmd = '{start: 1'b1, clear: 1'b1, sub: 1'b0};
                        mac_a   = 64'(rr_reg);
                        mac_b   = (W+1)'(rr_reg);
                    end
                end
                S_SQ2: begin
                    mac_cmd = '{start: 1'b1, clear: 1'b0, sub: 1'b0};
                    mac_a   = 64'(nxt_i_reg);
                    mac_b   = (W+1)'(nxt_i_reg);
                end
                S_B2: begin
                    mac_cmd = '{start: 1'b1, clear: 1'b0, sub: 1'b0};
                    mac_a   = 64'(ri_reg);
                    mac_b   = (W+1)'(ri_reg);
                end
                S_B3: begin
                    if (!(acc <= thr_ext) && !abort_reg
                        && !(drr_reg == '0 && dri_reg == '0)) begin
                        mac_cmd = '{start: 1'b1, clear: 1'b1, sub: 1'b0};
                        mac_a   = 64'(dsr_reg);
                        mac_b   = drr_reg;
                    end
                end
                S_N1: begin
                    mac_cmd = '{start: 1'b1, clear: 1'b0, sub: 1'b0};
                    mac_a   = 64'(dsi_reg);
                    mac_b   = dri_reg;
                end
                S_N2: begin
                    mac_cmd = '{start: 1'b1, clear: 1'b1, sub: 1'b0};
                    mac_a   = 64'(dsi_reg);
                    mac_b   = drr_reg;
                end
                S_N3: begin
                    mac_cmd = '{start: 1'b1, clear: 1'b0, sub: 1'b1};
                    mac_a   = 64'(dsr_reg);
                    mac_b   = dri_reg;
                end
                S_N4: begin
                    mac_cmd = '{start: 1'b1, clear: 1'b1, sub: 1'b0};
                    mac_a   = 64'(drr_reg);
                    mac_b   = drr_reg;
                end
                S_D1: begin
                    mac_cmd = '{start: 1'b1, clear: 1'b0, sub: 1'b0};
                    mac_a   = 64'(dri_reg);
                    mac_b   = dri_reg;
                end
                S_Q0: begin
                    div_cmd.start = 1'b1;
                end
                S_Q1: begin
                    if (!div_busy && !div_ovf) begin
                        div_cmd.start = 1'b1;
                        div_n         = nim_mag_reg;
                    end
                end
                S_C1: begin
                    mac_cmd = '{start: 1'b1, clear: 1'b1, sub: 1'b0};
                    mac_a   = kr_reg;
                    mac_b   = (W+1)'(rr_reg);
                end
                S_C2: begin
                    mac_cmd = '{start: 1'b1, clear: 1'b0, sub: 1'b1};
                    mac_a   = ki_reg;
                    mac_b   = (W+1)'(ri_reg);
                end
                S_C3: begin
                    mac_cmd = '{start: 1'b1, clear: 1'b1, sub: 1'b0};
                    mac_a   = kr_reg;
                    mac_b   = (W+1)'(ri_reg);
                end
                S_C4: begin
                    mac_cmd = '{start: 1'b1, clear: 1'b0, sub: 1'b0};
                    mac_a   = ki_reg;
                    mac_b   = (W+1)'(rr_reg);
                end
                S_C6: begin
                    mac_cmd = '{start: 1'b1, clear: 1'b1, sub: 1'b0};
                    mac_a   = 64'(nr_sat);
                    mac_b   = (W+1)'(nr_sat);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            thr_reg      <= '0;
            amp_reg      <= '1;
            maxs_reg     <= 8'd50;
            cnt_reg      <= '0;
            run_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            prev_sr_reg  <= '0;
            prev_si_reg  <= '0;
            prev_rr_reg  <= '0;
            prev_ri_reg  <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_THRESHOLD: thr_reg  <= cfg_wdata;
                    CFG_MAX_AMP:   amp_reg  <= cfg_wdata;
                    CFG_MAX_STEPS: maxs_reg <= cfg_wdata[7:0];
                    default: begin
                    end
                endcase
            end

            // in S_OUT a taken result is replaced by the next one below
            if (m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        sr_reg      <= s_tdata[W-1:0];
                        si_reg      <= s_tdata[2*W-1:W];
                        rr_reg      <= s_tdata[3*W-1:2*W];
                        ri_reg      <= s_tdata[4*W-1:3*W];
                        pr_reg      <= s_tdata[5*W-1:4*W];
                        pi_reg      <= s_tdata[6*W-1:5*W];
                        abort_reg   <= s_tdata[6*W];
                        first_reg   <= !s_tuser || !run_reg;
                        dsr_reg     <= (W+1)'($signed(s_tdata[W-1:0])) - (W+1)'(prev_sr_reg);
                        dsi_reg     <= (W+1)'($signed(s_tdata[2*W-1:W])) - (W+1)'(prev_si_reg);
                        drr_reg     <= (W+1)'($signed(s_tdata[3*W-1:2*W]))
                                       - (W+1)'(prev_rr_reg);
                        dri_reg     <= (W+1)'($signed(s_tdata[4*W-1:3*W]))
                                       - (W+1)'(prev_ri_reg);
                        prev_sr_reg <= s_tdata[W-1:0];
                        prev_si_reg <= s_tdata[2*W-1:W];
                        prev_rr_reg <= s_tdata[3*W-1:2*W];
                        prev_ri_reg <= s_tdata[4*W-1:3*W];
                        state_reg   <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (first_reg) begin
                        nxt_r_reg <= nr_sat;
                        nxt_i_reg <= ni_sat;
                        satd_reg  <= sat_any;
                        state_reg <= S_SQ2;
                    end else if (k_limit) begin
                        res_r_reg   <= sr_reg;
                        res_i_reg   <= si_reg;
                        res_st_reg  <= ST_STEP_LIMIT;
                        res_idx_reg <= cnt_reg;
                        run_reg     <= 1'b0;
                        state_reg   <= S_OUT;
                    end else begin
                        state_reg <= S_B2;
                    end
                end
                S_SQ2: begin
                    if (!mac_busy) begin
                        state_reg <= S_SQ3;
                    end
                end
                S_SQ3: begin
                    if (!mac_busy) begin
                        state_reg <= S_OUT;
                        if (over_amp) begin
                            res_r_reg   <= sr_reg;
                            res_i_reg   <= si_reg;
                            res_st_reg  <= ST_OVERRANGE;
                            res_idx_reg <= first_reg ? 8'd0 : cnt_reg;
                            run_reg     <= 1'b0;
                            if (first_reg) begin
                                cnt_reg <= '0;
                            end
                        end else begin
                            res_r_reg   <= nxt_r_reg;
                            res_i_reg   <= nxt_i_reg;
                            res_st_reg  <= ST_APPLY;
                            res_idx_reg <= first_reg ? 8'd1 : k_w[7:0];
                            cnt_reg     <= first_reg ? 8'd1 : k_w[7:0];
                            run_reg     <= 1'b1;
                        end
                    end
                end
                S_B2: begin
                    if (!mac_busy) begin
                        state_reg <= S_B3;
                    end
                end
                S_B3: begin
                    if (!mac_busy) begin
                        res_r_reg   <= sr_reg;
                        res_i_reg   <= si_reg;
                        res_idx_reg <= cnt_reg;
                        if (acc <= thr_ext) begin
                            res_st_reg <= ST_BALANCED;
                            run_reg    <= 1'b0;
                            state_reg  <= S_OUT;
                        end else if (abort_reg) begin
                            res_st_reg <= ST_ABORTED;
                            run_reg    <= 1'b0;
                            state_reg  <= S_OUT;
                        end else if (drr_reg == '0 && dri_reg == '0) begin
                            res_st_reg <= ST_SINGULAR;
                            run_reg    <= 1'b0;
                            state_reg  <= S_OUT;
                        end else begin
                            state_reg <= S_N1;
                        end
                    end
                end
                S_N1: begin
                    if (!mac_busy) begin
                        state_reg <= S_N2;
                    end
                end
                S_N2: begin
                    if (!mac_busy) begin
                        nre_neg_reg <= acc[ACC_W-1];
                        nre_mag_reg <= acc_mag[NM_W-1:0];
                        state_reg   <= S_N3;
                    end
                end
                S_N3: begin
                    if (!mac_busy) begin
                        state_reg <= S_N4;
                    end
                end
                S_N4: begin
                    if (!mac_busy) begin
                        nim_neg_reg <= acc[ACC_W-1];
                        nim_mag_reg <= acc_mag[NM_W-1:0];
                        state_reg   <= S_D1;
                    end
                end
                S_D1: begin
                    if (!mac_busy) begin
                        state_reg <= S_D2;
                    end
                end
                S_D2: begin
                    if (!mac_busy) begin
                        d_reg     <= acc_mag[NM_W-1:0];
                        state_reg <= S_Q0;
                    end
                end
                S_Q0: begin
                    state_reg <= S_Q1;
                end
                S_Q1: begin
                    if (!div_busy) begin
                        if (div_ovf) begin
                            res_st_reg <= ST_SINGULAR;
                            run_reg    <= 1'b0;
                            state_reg  <= S_OUT;
                        end else begin
                            kr_reg    <= nre_neg_reg ? -q_signed : q_signed;
                            state_reg <= S_Q2;
                        end
                    end
                end
                S_Q2: begin
                    if (!div_busy) begin
                        if (div_ovf) begin
                            res_st_reg <= ST_SINGULAR;
                            run_reg    <= 1'b0;
                            state_reg  <= S_OUT;
                        end else begin
                            ki_reg    <= nim_neg_reg ? -q_signed : q_signed;
                            state_reg <= S_C1;
                        end
                    end
                end
                S_C1: begin
                    state_reg <= S_C2;
                end
                S_C2: begin
                    if (!mac_busy) begin
                        state_reg <= S_C3;
                    end
                end
                S_C3: begin
                    if (!mac_busy) begin
                        cr_reg    <= c_val;
                        state_reg <= S_C4;
                    end
                end
                S_C4: begin
                    if (!mac_busy) begin
                        state_reg <= S_C5;
                    end
                end
                S_C5: begin
                    if (!mac_busy) begin
                        ci_reg    <= c_val;
                        state_reg <= S_C6;
                    end
                end
                S_C6: begin
                    nxt_r_reg <= nr_sat;
                    nxt_i_reg <= ni_sat;
                    satd_reg  <= sat_any;
                    state_reg <= S_SQ2;
                end
                S_OUT: begin
                    // hold the result until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_r_reg      <= res_r_reg;
                        m_i_reg      <= res_i_reg;
                        m_st_reg     <= res_st_reg;
                        m_idx_reg    <= res_idx_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({m_idx_reg, m_st_reg, m_i_reg, m_r_reg});

endmodule
